// ===== design/cpu16_pkg.sv =====
// ---------------------------------------------------------------------------
// cpu16_pkg: shared types and helpers for the 16-bit register file and ALU
// Holds the operation codes, the instruction and result records, the write
// request of the register file and the byte/word register view helpers.
// ---------------------------------------------------------------------------
package cpu16_pkg;

    localparam int GprAw = 3;
    localparam int DataW = 16;
    localparam int ByteW = 8;

    localparam logic [2:0] OP_MOVE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_CMP  = 3'd3;
    localparam logic [2:0] OP_JNZ  = 3'd4;

    // One decoded instruction as it sits in the input register.
    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        dst;
        logic              use_imm;
        logic [3:0]        src;
        logic [DataW-1:0]  imm;
        logic signed [7:0] offset;
    } t_instr;

    // Write request into the general register file (whole word, already merged).
    typedef struct packed {
        logic             we;
        logic [GprAw-1:0] addr;
        logic [DataW-1:0] data;
    } t_gpr_wr;

    // Result beat and the architectural state it reports.
    typedef struct packed {
        logic [DataW-1:0] written;
        logic             wrote;
        logic             zf;
        logic             sf;
        logic [DataW-1:0] ip;
    } t_result;

    // Word index behind a register selector: words 8..15 map to 0..7,
    // byte views 0..7 map to the low four words.
    function automatic logic [GprAw-1:0] word_index(input logic [3:0] sel);
        return sel[3] ? sel[2:0] : {1'b0, sel[1:0]};
    endfunction

    // Operand as seen through a selector: full word, or one byte zero-extended.
    function automatic logic [DataW-1:0] reg_view(input logic [DataW-1:0] word,
                                                  input logic [3:0]       sel);
        logic [DataW-1:0] v;
        if (sel[3]) begin
            v = word;
        end else if (sel[2]) begin
            v = {{(DataW-ByteW){1'b0}}, word[DataW-1:ByteW]};
        end else begin
            v = {{(DataW-ByteW){1'b0}}, word[ByteW-1:0]};
        end
        return v;
    endfunction

endpackage

// ===== design/cpu16_regfile.sv =====
// ---------------------------------------------------------------------------
// cpu16_regfile: eight 16-bit general registers
// One write port and two registered read ports; a read that coincides with
// a write to the same word returns the new word.
// ---------------------------------------------------------------------------
module cpu16_regfile (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpu16_pkg::t_gpr_wr                i_wr,
    input  logic                              i_rd_en,
    input  logic [cpu16_pkg::GprAw-1:0]       i_rd_addr_a,
    input  logic [cpu16_pkg::GprAw-1:0]       i_rd_addr_b,
    output logic [cpu16_pkg::DataW-1:0]       o_rd_data_a,
    output logic [cpu16_pkg::DataW-1:0]       o_rd_data_b
);

    logic [cpu16_pkg::DataW-1:0] r_gpr [2**cpu16_pkg::GprAw];
    logic [cpu16_pkg::DataW-1:0] r_rd_a;
    logic [cpu16_pkg::DataW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2**cpu16_pkg::GprAw; i++) begin
                r_gpr[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_gpr[i_wr.addr] <= i_wr.data;
        end
    end

    // Bypass keeps the read coherent with a write landing on the same edge.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= (i_wr.we && i_wr.addr == i_rd_addr_a) ? i_wr.data : r_gpr[i_rd_addr_a];
            r_rd_b <= (i_wr.we && i_wr.addr == i_rd_addr_b) ? i_wr.data : r_gpr[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== design/cpu16_alu.sv =====
// ---------------------------------------------------------------------------
// cpu16_alu: execute one instruction
// Forms the operands, adds or subtracts at the destination width, updates
// the flags and the pointer, and builds the merged register write.
// ---------------------------------------------------------------------------
module cpu16_alu (
    input  cpu16_pkg::t_instr                i_instr,
    input  logic [cpu16_pkg::DataW-1:0]      i_dst_word,
    input  logic [cpu16_pkg::DataW-1:0]      i_src_word,
    input  logic                             i_zf,
    input  logic                             i_sf,
    input  logic [cpu16_pkg::DataW-1:0]      i_ip,
    output cpu16_pkg::t_gpr_wr               o_wr,
    output cpu16_pkg::t_result               o_result
);

    localparam int DW = cpu16_pkg::DataW;
    localparam int BW = cpu16_pkg::ByteW;

    logic          wide;
    logic [DW-1:0] src_raw;
    logic [DW-1:0] src_val;
    logic [DW-1:0] dst_val;
    logic [DW-1:0] sum;
    logic [DW-1:0] diff;
    logic [DW-1:0] alu_res;
    logic [DW-1:0] merged;
    logic          do_write;
    logic [DW-1:0] wr_val;

    assign wide    = i_instr.dst[3];
    assign src_raw = i_instr.use_imm ? i_instr.imm
                                     : cpu16_pkg::reg_view(i_src_word, i_instr.src);
    assign src_val = wide ? src_raw : {{(DW-BW){1'b0}}, src_raw[BW-1:0]};
    assign dst_val = cpu16_pkg::reg_view(i_dst_word, i_instr.dst);
    assign sum     = dst_val + src_val;
    assign diff    = dst_val - src_val;

    always_comb begin
        alu_res = (i_instr.op == cpu16_pkg::OP_ADD) ? sum : diff;
        if (!wide) begin
            alu_res = {{(DW-BW){1'b0}}, alu_res[BW-1:0]};
        end
    end

    always_comb begin
        do_write        = 1'b0;
        wr_val          = '0;
        o_result.zf     = i_zf;
        o_result.sf     = i_sf;
        o_result.ip     = i_ip;
        case (i_instr.op)
            cpu16_pkg::OP_MOVE: begin
                do_write = 1'b1;
                wr_val   = src_val;
            end
            cpu16_pkg::OP_ADD, cpu16_pkg::OP_SUB: begin
                do_write    = 1'b1;
                wr_val      = alu_res;
                o_result.zf = (alu_res == '0);
                o_result.sf = wide ? alu_res[DW-1] : alu_res[BW-1];
            end
            cpu16_pkg::OP_CMP: begin
                o_result.zf = (alu_res == '0);
                o_result.sf = wide ? alu_res[DW-1] : alu_res[BW-1];
            end
            cpu16_pkg::OP_JNZ: begin
                if (!i_zf) begin
                    o_result.ip = i_ip + {{(DW-8){i_instr.offset[7]}}, i_instr.offset};
                end
            end
            default: begin
            end
        endcase
        o_result.written = wr_val;
        o_result.wrote   = do_write;
    end

    // Byte writes keep the other half of the word.
    always_comb begin
        if (wide) begin
            merged = wr_val;
        end else if (i_instr.dst[2]) begin
            merged = {wr_val[BW-1:0], i_dst_word[BW-1:0]};
        end else begin
            merged = {i_dst_word[DW-1:BW], wr_val[BW-1:0]};
        end
    end

    assign o_wr.we          = do_write;
    assign o_wr.addr        = cpu16_pkg::word_index(i_instr.dst);
    assign o_wr.data        = merged;

endmodule

// ===== design/cpu16_register_file_alu_step_unit.sv =====
// Flow: input register, then execute into the result register once it is free.
// Throughput: one instruction per cycle while result beats are taken, set by
// the single register-file write port and the one adder; the next instruction
// sees the state left by this one.
// Reset (synchronous, active low) clears all registers, flags and the pointer.
// ---------------------------------------------------------------------------
// cpu16_register_file_alu_step_unit: register file and ALU step, top level
// Input register, register file with registered reads, combinational ALU
// and a result register, with stream handshakes on both sides.
// ---------------------------------------------------------------------------
module cpu16_register_file_alu_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Instruction beat.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] dest_register, [7:4] source_register, [23:8] immediate_value,
    // [31:24] jump_offset
    input  logic [31:0] i_s_axis_tdata,
    // [2:0] operation, [3] source_is_immediate
    input  logic [3:0]  i_s_axis_tuser,
    // Result beat.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] written_value, [16] zero_flag, [17] sign_flag,
    // [33:18] instruction_pointer, [39:34] zero
    output logic [39:0] o_m_axis_tdata,
    // [0] wrote_register
    output logic        o_m_axis_tuser
);

    localparam int DW = cpu16_pkg::DataW;

    // Pipeline control. The input register drains whenever the result
    // register is free or being emptied this cycle, so while result beats are
    // taken, a new instruction can be accepted on every edge.
    logic               s_accept;
    logic               out_free;
    logic               exec;
    logic               r_in_valid;
    logic               n_in_valid;
    logic               r_out_valid;
    logic               n_out_valid;

    cpu16_pkg::t_instr  in_instr;
    cpu16_pkg::t_instr  r_instr;

    // Architectural state beside the register file.
    logic               r_zf;
    logic               r_sf;
    logic [DW-1:0]      r_ip;

    logic [DW-1:0]      dst_word;
    logic [DW-1:0]      src_word;
    cpu16_pkg::t_gpr_wr alu_wr;
    cpu16_pkg::t_gpr_wr gpr_wr;
    cpu16_pkg::t_result alu_result;
    cpu16_pkg::t_result r_result;

    assign in_instr.op      = i_s_axis_tuser[2:0];
    assign in_instr.use_imm = i_s_axis_tuser[3];
    assign in_instr.dst     = i_s_axis_tdata[3:0];
    assign in_instr.src     = i_s_axis_tdata[7:4];
    assign in_instr.imm     = i_s_axis_tdata[23:8];
    assign in_instr.offset  = i_s_axis_tdata[31:24];

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign exec            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (exec) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_instr <= in_instr;
        end
    end

    // Operand words are read as the instruction enters the input register;
    // the register file forwards a write from the instruction retiring on
    // the same edge, so back-to-back dependencies see the new value.
    assign gpr_wr.we   = alu_wr.we && exec;
    assign gpr_wr.addr = alu_wr.addr;
    assign gpr_wr.data = alu_wr.data;

    cpu16_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (gpr_wr),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (cpu16_pkg::word_index(in_instr.dst)),
        .i_rd_addr_b (cpu16_pkg::word_index(in_instr.src)),
        .o_rd_data_a (dst_word),
        .o_rd_data_b (src_word)
    );

    cpu16_alu u_alu (
        .i_instr    (r_instr),
        .i_dst_word (dst_word),
        .i_src_word (src_word),
        .i_zf       (r_zf),
        .i_sf       (r_sf),
        .i_ip       (r_ip),
        .o_wr       (alu_wr),
        .o_result   (alu_result)
    );

    // Flags and pointer retire together with the register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zf <= 1'b0;
            r_sf <= 1'b0;
            r_ip <= '0;
        end else if (exec) begin
            r_zf <= alu_result.zf;
            r_sf <= alu_result.sf;
            r_ip <= alu_result.ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= alu_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_result.ip, r_result.sf, r_result.zf, r_result.written};
    assign o_m_axis_tuser  = r_result.wrote;

endmodule

// ===== design/cpu16_checker.sv =====
// ---------------------------------------------------------------------------
// cpu16_checker: port-level checks for the register file and ALU step
// Watches the handshakes and result beats of the top level; bound below.
// ---------------------------------------------------------------------------
module cpu16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A result beat that is not taken stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // With no result waiting, the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

    // Instructions that write nothing report a zero value.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[15:0] == 16'h0000)
        else $error("nonzero written value without a write");

endmodule

bind cpu16_register_file_alu_step_unit cpu16_checker u_cpu16_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== bench/tb_cpu16_register_file_alu_step_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cpu16_register_file_alu_step_unit: self-checking bench for the ALU step
// Drives decoded instructions in bursts, predicts every result beat from a
// private copy of the registers, flags and pointer, and compares each beat
// field by field while the result side stalls at random.
// ---------------------------------------------------------------------------

// Tracks the architectural state and the results still owed by the block.
class cpu16_step_scoreboard;

    logic [15:0]         gpr_words [8];
    logic [15:0]         ip_now;
    logic                zf_now;
    logic                sf_now;
    cpu16_pkg::t_result  step_results_q[$];
    int unsigned         mismatches;
    int unsigned         results_checked;

    function new();
        foreach (gpr_words[i]) gpr_words[i] = '0;
        ip_now          = '0;
        zf_now          = 1'b0;
        sf_now          = 1'b0;
        mismatches      = 0;
        results_checked = 0;
    endfunction

    // Word registers come back whole, byte views zero-extended.
    function logic [15:0] view_of(logic [3:0] sel);
        if (sel[3]) begin
            return gpr_words[sel[2:0]];
        end else if (sel[2]) begin
            return {8'h00, gpr_words[sel[1:0]][15:8]};
        end
        return {8'h00, gpr_words[sel[1:0]][7:0]};
    endfunction

    // A byte write only replaces its own half of the word.
    function void store_to(logic [3:0] sel, logic [15:0] value);
        if (sel[3]) begin
            gpr_words[sel[2:0]] = value;
        end else if (sel[2]) begin
            gpr_words[sel[1:0]] = {value[7:0], gpr_words[sel[1:0]][7:0]};
        end else begin
            gpr_words[sel[1:0]] = {gpr_words[sel[1:0]][15:8], value[7:0]};
        end
    endfunction

    // Executes one accepted instruction and queues the beat it must produce.
    function void record_instruction(cpu16_pkg::t_instr ins);
        logic               wide;
        logic [15:0]        width_mask;
        logic [15:0]        src_val;
        logic [15:0]        dst_val;
        logic [15:0]        alu_out;
        cpu16_pkg::t_result res;
        wide       = ins.dst[3];
        width_mask = wide ? 16'hFFFF : 16'h00FF;
        src_val    = (ins.use_imm ? ins.imm : view_of(ins.src)) & width_mask;
        dst_val    = view_of(ins.dst);
        res        = '0;
        case (ins.op)
            cpu16_pkg::OP_MOVE: begin
                store_to(ins.dst, src_val);
                res.written = src_val;
                res.wrote   = 1'b1;
            end
            cpu16_pkg::OP_ADD, cpu16_pkg::OP_SUB, cpu16_pkg::OP_CMP: begin
                alu_out = (ins.op == cpu16_pkg::OP_ADD) ? dst_val + src_val
                                                        : dst_val - src_val;
                alu_out = alu_out & width_mask;
                zf_now  = (alu_out == 16'h0000);
                sf_now  = wide ? alu_out[15] : alu_out[7];
                if (ins.op != cpu16_pkg::OP_CMP) begin
                    store_to(ins.dst, alu_out);
                    res.written = alu_out;
                    res.wrote   = 1'b1;
                end
            end
            cpu16_pkg::OP_JNZ: begin
                if (!zf_now) begin
                    ip_now = ip_now + {{8{ins.offset[7]}}, ins.offset};
                end
            end
            default: begin
                // Unused codes leave everything alone.
            end
        endcase
        res.zf = zf_now;
        res.sf = sf_now;
        res.ip = ip_now;
        step_results_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(cpu16_pkg::t_result got);
        cpu16_pkg::t_result want;
        results_checked++;
        if (step_results_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = step_results_q.pop_front();
        compare_field("written_value", want.written, got.written);
        compare_field("wrote_register", 16'(want.wrote), 16'(got.wrote));
        compare_field("zero_flag", 16'(want.zf), 16'(got.zf));
        compare_field("sign_flag", 16'(want.sf), 16'(got.sf));
        compare_field("instruction_pointer", want.ip, got.ip);
    endfunction

    function int unsigned pending();
        return step_results_q.size();
    endfunction

endclass

module tb_cpu16_register_file_alu_step_unit;

    localparam int unsigned RandomItems   = 1200;
    localparam int unsigned HoldOffCycles = 300;
    localparam int unsigned IdleLimit     = 5000;

    // Operation codes with no defined behavior.
    localparam logic [2:0]  OpUnusedLo    = 3'd5;
    localparam logic [2:0]  OpUnusedHi    = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [3:0] dest_register, [7:4] source_register, [23:8] immediate_value,
    // [31:24] jump_offset
    logic [31:0] i_s_axis_tdata;
    // [2:0] operation, [3] source_is_immediate
    logic [3:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [15:0] written_value, [16] zero_flag, [17] sign_flag,
    // [33:18] instruction_pointer, [39:34] zero
    logic [39:0] o_m_axis_tdata;
    // [0] wrote_register
    logic        o_m_axis_tuser;

    cpu16_step_scoreboard sb;

    cpu16_register_file_alu_step_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic cpu16_pkg::t_instr make_instr(logic [2:0] op, logic [3:0] dst,
                                                     logic use_imm, logic [3:0] src,
                                                     logic [15:0] imm,
                                                     logic [7:0] offset);
        cpu16_pkg::t_instr ins;
        ins.op      = op;
        ins.dst     = dst;
        ins.use_imm = use_imm;
        ins.src     = src;
        ins.imm     = imm;
        ins.offset  = offset;
        return ins;
    endfunction

    // Mostly real operations with edge-heavy immediates; a few unused codes.
    function automatic cpu16_pkg::t_instr random_instr();
        int unsigned pick;
        logic [2:0]  op;
        logic [15:0] imm;
        pick = $urandom_range(0, 99);
        if (pick < 20)      op = cpu16_pkg::OP_MOVE;
        else if (pick < 40) op = cpu16_pkg::OP_ADD;
        else if (pick < 60) op = cpu16_pkg::OP_SUB;
        else if (pick < 75) op = cpu16_pkg::OP_CMP;
        else if (pick < 97) op = cpu16_pkg::OP_JNZ;
        else                op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
        case ($urandom_range(0, 7))
            0:       imm = 16'h0000;
            1:       imm = 16'hFFFF;
            2:       imm = 16'h8000;
            3:       imm = 16'h0001;
            4:       imm = 16'(16'h00FF << ($urandom_range(0, 1) * 8));
            default: imm = 16'($urandom());
        endcase
        return make_instr(op, 4'($urandom()), 1'($urandom()), 4'($urandom()), imm,
                          8'($urandom()));
    endfunction

    // Offers one instruction from the next falling edge until it is taken.
    task automatic send_instr(cpu16_pkg::t_instr ins);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ins.offset, ins.imm, ins.src, ins.dst};
        i_s_axis_tuser  <= {ins.use_imm, ins.op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.record_instruction(ins);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Result side: each accepted beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        cpu16_pkg::t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.written = o_m_axis_tdata[15:0];
            got.zf      = o_m_axis_tdata[16];
            got.sf      = o_m_axis_tdata[17];
            got.ip      = o_m_axis_tdata[33:18];
            got.wrote   = o_m_axis_tuser;
            sb.check_result(got);
        end
    end

    // Receiver stalls in stretches of its own; once, it holds off long enough
    // for the block to fill up and push back on the instruction side.
    initial begin
        int unsigned mode;
        int unsigned stretch;
        bit          held_off;
        i_m_axis_tready = 1'b0;
        held_off        = 1'b0;
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(negedge i_clk);
                if (!held_off && sb.results_checked >= 400) begin
                    held_off = 1'b1;
                    i_m_axis_tready <= 1'b0;
                    repeat (HoldOffCycles) @(negedge i_clk);
                end
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom());
                    default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Ends the run if neither side moves a beat for too long.
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IdleLimit) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        cpu16_pkg::t_instr directed_q[$];
        int unsigned       sent;
        int unsigned       burst_left;
        sb              = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: byte views and merging, masking of byte results,
        // flags at both widths, compare without write, jumps taken and not
        // taken with wrap of the pointer, and the unused operation codes.
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd8,  1'b1, 4'd0,
                                        16'hFFFF, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd0,  1'b1, 4'd15,
                                        16'h1234, 8'hFF));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd4,  1'b1, 4'd0,
                                        16'h00AB, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd11, 1'b0, 4'd8,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd1,  1'b0, 4'd4,
                                        16'hFFFF, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd10, 1'b0, 4'd1,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_ADD,  4'd0,  1'b1, 4'd0,
                                        16'hFFCC, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd0,  1'b0, 4'd0,
                                        16'h0000, 8'h05));
        directed_q.push_back(make_instr(cpu16_pkg::OP_ADD,  4'd8,  1'b1, 4'd0,
                                        16'h0001, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd15, 1'b1, 4'd15,
                                        16'hFFFF, 8'h7F));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd0,  1'b0, 4'd0,
                                        16'h0000, 8'h80));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd0,  1'b0, 4'd0,
                                        16'h0000, 8'hFF));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd0,  1'b0, 4'd0,
                                        16'h0000, 8'h02));
        directed_q.push_back(make_instr(cpu16_pkg::OP_SUB,  4'd15, 1'b1, 4'd0,
                                        16'h0001, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_ADD,  4'd15, 1'b0, 4'd15,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_CMP,  4'd15, 1'b1, 4'd0,
                                        16'hFFFE, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_SUB,  4'd7,  1'b0, 4'd7,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_CMP,  4'd12, 1'b1, 4'd0,
                                        16'h8000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_SUB,  4'd5,  1'b1, 4'd0,
                                        16'hAA01, 8'h00));
        directed_q.push_back(make_instr(OpUnusedLo,         4'd8,  1'b1, 4'd0,
                                        16'h5555, 8'h10));
        directed_q.push_back(make_instr(OpUnusedHi,         4'd3,  1'b0, 4'd9,
                                        16'h0000, 8'h10));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd14, 1'b1, 4'd0,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_MOVE, 4'd12, 1'b0, 4'd14,
                                        16'h0000, 8'h00));
        directed_q.push_back(make_instr(cpu16_pkg::OP_JNZ,  4'd0,  1'b0, 4'd0,
                                        16'h0000, 8'h40));
        foreach (directed_q[i]) begin
            send_instr(directed_q[i]);
            idle_sender($urandom_range(0, 2));
        end

        // Random part: bursts of random length separated by random gaps, some
        // of them back to back with no gap at all.
        sent = 0;
        while (sent < RandomItems) begin
            burst_left = $urandom_range(1, 40);
            while (burst_left > 0 && sent < RandomItems) begin
                send_instr(random_instr());
                sent++;
                burst_left--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        idle_sender(1);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
